[hw/rtl/cheb2_pkg.sv]
// Shared types, constants and fixed-point helpers for the 2-D Chebyshev basis evaluator.
package cheb2_pkg;

  // Degree limits and field widths
  localparam int MAX_ORDER = 7;
  localparam int ORD_W     = 3;
  localparam int VAL_W     = 32;
  localparam int SCALE_W   = 31;
  localparam int PROD_W    = 64;

  // Request queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  // 1.0 in Q4.27
  localparam logic signed [VAL_W-1:0] ONE_Q27 = 32'sh0800_0000;

  localparam logic signed [PROD_W-1:0] SAT_HI = 64'sd2147483647;
  localparam logic signed [PROD_W-1:0] SAT_LO = -64'sd2147483648;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_X_ORDER = 3'd0,
    REG_Y_ORDER = 3'd1,
    REG_X_UPPER = 3'd2,
    REG_Y_UPPER = 3'd3,
    REG_X_SCALE = 3'd4,
    REG_Y_SCALE = 3'd5
  } cfg_reg_e;

  // Configuration register file contents
  typedef struct packed {
    logic [ORD_W-1:0]          x_order;
    logic [ORD_W-1:0]          y_order;
    logic signed [VAL_W-1:0]   x_upper;
    logic signed [VAL_W-1:0]   y_upper;
    logic [SCALE_W-1:0]        x_scale;
    logic [SCALE_W-1:0]        y_scale;
  } cfg_t;

  // One mapped point, ready for the polynomial and product work
  typedef struct packed {
    logic signed [VAL_W-1:0] xm;
    logic signed [VAL_W-1:0] ym;
    logic [ORD_W-1:0]        ox;
    logic [ORD_W-1:0]        oy;
  } job_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_RND,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_INIT,
    B_MUL,
    B_ACC,
    B_EMIT
  } back_state_t;

  // Arithmetic shift right by s, rounding to nearest, ties toward +inf
  function automatic logic signed [PROD_W-1:0] rnd_shr(input logic signed [PROD_W-1:0] v,
                                                        input int unsigned s);
    logic signed [PROD_W-1:0] bias;
    bias = 64'sd1 <<< (s - 1);
    return (v + bias) >>> s;
  endfunction

  // Clamp to the signed 32-bit range
  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [VAL_W-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[VAL_W-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[VAL_W-1:0];
    end else begin
      r = v[VAL_W-1:0];
    end
    return r;
  endfunction

endpackage

[hw/rtl/cheb2_front.sv]
// Front end: takes a point request, clips orders and maps both coordinates onto [-1,1].
module cheb2_front #(
  parameter int MAX_ORDER = cheb2_pkg::MAX_ORDER
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [cheb2_pkg::VAL_W-1:0]   x_coord,
  input  logic signed [cheb2_pkg::VAL_W-1:0]   y_coord,
  input  cheb2_pkg::cfg_t                      cfg,
  output logic                                 push_valid,
  output cheb2_pkg::job_t                      push_data,
  input  logic                                 q_full
);

  localparam logic [cheb2_pkg::ORD_W-1:0] ORD_MAX = cheb2_pkg::ORD_W'(MAX_ORDER);

  cheb2_pkg::front_state_t state_r, state_nxt;

  logic signed [cheb2_pkg::VAL_W:0]    diff_x_r, diff_y_r;
  logic signed [cheb2_pkg::PROD_W-1:0] mprod_x_r, mprod_y_r;
  logic signed [cheb2_pkg::PROD_W:0]   mp_x, mp_y;
  logic [cheb2_pkg::ORD_W-1:0]         ox_r, oy_r;
  logic signed [cheb2_pkg::VAL_W-1:0]  xm_r, ym_r;
  logic                                accept;

  assign accept = start && !busy;

  // Scale multiply: 33-bit signed difference times 31-bit unsigned scale
  assign mp_x = diff_x_r * $signed({1'b0, cfg.x_scale});
  assign mp_y = diff_y_r * $signed({1'b0, cfg.y_scale});

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cheb2_pkg::F_IDLE: if (start) state_nxt = cheb2_pkg::F_MUL;
      cheb2_pkg::F_MUL:  state_nxt = cheb2_pkg::F_RND;
      cheb2_pkg::F_RND:  state_nxt = cheb2_pkg::F_PUSH;
      cheb2_pkg::F_PUSH: if (!q_full) state_nxt = cheb2_pkg::F_IDLE;
      default:           state_nxt = cheb2_pkg::F_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    busy       = 1'b1;
    push_valid = 1'b0;
    case (state_r)
      cheb2_pkg::F_IDLE: busy = 1'b0;
      cheb2_pkg::F_PUSH: push_valid = !q_full;
      default: begin
        busy       = 1'b1;
        push_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cheb2_pkg::F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath: difference, product, round and offset
  always_ff @(posedge clk) begin
    if (accept) begin
      diff_x_r <= (cheb2_pkg::VAL_W+1)'(x_coord) - (cheb2_pkg::VAL_W+1)'(cfg.x_upper);
      diff_y_r <= (cheb2_pkg::VAL_W+1)'(y_coord) - (cheb2_pkg::VAL_W+1)'(cfg.y_upper);
      ox_r     <= (cfg.x_order > ORD_MAX) ? ORD_MAX : cfg.x_order;
      oy_r     <= (cfg.y_order > ORD_MAX) ? ORD_MAX : cfg.y_order;
    end
    if (state_r == cheb2_pkg::F_MUL) begin
      mprod_x_r <= mp_x[cheb2_pkg::PROD_W-1:0];
      mprod_y_r <= mp_y[cheb2_pkg::PROD_W-1:0];
    end
    if (state_r == cheb2_pkg::F_RND) begin
      xm_r <= cheb2_pkg::sat32(cheb2_pkg::rnd_shr(mprod_x_r, 13)
                               + cheb2_pkg::PROD_W'(cheb2_pkg::ONE_Q27));
      ym_r <= cheb2_pkg::sat32(cheb2_pkg::rnd_shr(mprod_y_r, 13)
                               + cheb2_pkg::PROD_W'(cheb2_pkg::ONE_Q27));
    end
  end

  assign push_data = '{xm: xm_r, ym: ym_r, ox: ox_r, oy: oy_r};

endmodule

[hw/rtl/cheb2_queue.sv]
// Two-entry request queue between the front end and the back end.
module cheb2_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  input  cheb2_pkg::job_t push_data,
  output logic            full,
  input  logic            pop,
  output cheb2_pkg::job_t pop_data,
  output logic            empty
);

  cheb2_pkg::job_t                  q_r [cheb2_pkg::Q_DEPTH];
  logic [cheb2_pkg::Q_PTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [cheb2_pkg::Q_CNT_W-1:0]    cnt_r;
  logic                             do_push, do_pop;

  assign full     = (cnt_r == cheb2_pkg::Q_CNT_W'(cheb2_pkg::Q_DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push_valid && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = q_r[rd_ptr_r];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) q_r[wr_ptr_r] <= push_data;
  end

endmodule

[hw/rtl/cheb2_back.sv]
// Back end: Chebyshev recurrence on a shared multiplier, then one basis product per cycle.
module cheb2_back #(
  parameter int MAX_ORDER = cheb2_pkg::MAX_ORDER
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_empty,
  input  cheb2_pkg::job_t                     q_data,
  output logic                                q_pop,
  output logic                                out_valid,
  output logic [cheb2_pkg::ORD_W-1:0]         out_x_degree,
  output logic [cheb2_pkg::ORD_W-1:0]         out_y_degree,
  output logic signed [cheb2_pkg::VAL_W-1:0]  out_basis_value,
  output logic                                out_last
);

  localparam int DEPTH = MAX_ORDER + 1;
  localparam int IDX_W = (MAX_ORDER > 0) ? $clog2(DEPTH) : 1;

  cheb2_pkg::back_state_t state_r, state_nxt;

  cheb2_pkg::job_t                     job_r;
  logic                                axis_r;
  logic [cheb2_pkg::ORD_W-1:0]         n_r, ei_r, ej_r;
  logic signed [cheb2_pkg::VAL_W-1:0]  t1_r, t2_r;
  logic signed [cheb2_pkg::PROD_W-1:0] rprod_r;
  logic signed [cheb2_pkg::VAL_W-1:0]  xs_r [DEPTH];
  logic signed [cheb2_pkg::VAL_W-1:0]  ys_r [DEPTH];

  // Emit pipeline: store read, multiply, round and saturate
  logic                                s1_valid_r, s2_valid_r, s3_valid_r;
  logic signed [cheb2_pkg::VAL_W-1:0]  s1_xv_r, s1_yv_r;
  logic signed [cheb2_pkg::PROD_W-1:0] s2_prod_r;
  logic [cheb2_pkg::ORD_W-1:0]         s1_i_r, s1_j_r, s2_i_r, s2_j_r, s3_i_r, s3_j_r;
  logic                                s1_last_r, s2_last_r, s3_last_r;
  logic signed [cheb2_pkg::VAL_W-1:0]  s3_val_r;

  logic signed [cheb2_pkg::VAL_W-1:0]  cur_v, tn;
  logic [cheb2_pkg::ORD_W-1:0]         cur_ord;
  logic                                axis_done, issue, issue_last;

  assign cur_v   = axis_r ? job_r.ym : job_r.xm;
  assign cur_ord = axis_r ? job_r.oy : job_r.ox;
  assign tn      = cheb2_pkg::sat32(cheb2_pkg::rnd_shr(rprod_r, 26)
                                    - cheb2_pkg::PROD_W'(t2_r));

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cheb2_pkg::B_IDLE: if (!q_empty) state_nxt = cheb2_pkg::B_INIT;
      cheb2_pkg::B_INIT: begin
        if (cur_ord < 3'd2) begin
          state_nxt = axis_r ? cheb2_pkg::B_EMIT : cheb2_pkg::B_INIT;
        end else begin
          state_nxt = cheb2_pkg::B_MUL;
        end
      end
      cheb2_pkg::B_MUL: state_nxt = cheb2_pkg::B_ACC;
      cheb2_pkg::B_ACC: begin
        if (n_r == cur_ord) begin
          state_nxt = axis_r ? cheb2_pkg::B_EMIT : cheb2_pkg::B_INIT;
        end else begin
          state_nxt = cheb2_pkg::B_MUL;
        end
      end
      cheb2_pkg::B_EMIT: if (issue_last) state_nxt = cheb2_pkg::B_IDLE;
      default:           state_nxt = cheb2_pkg::B_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    q_pop      = 1'b0;
    axis_done  = 1'b0;
    issue      = 1'b0;
    issue_last = 1'b0;
    case (state_r)
      cheb2_pkg::B_IDLE: q_pop = !q_empty;
      cheb2_pkg::B_INIT: axis_done = (cur_ord < 3'd2);
      cheb2_pkg::B_ACC:  axis_done = (n_r == cur_ord);
      cheb2_pkg::B_EMIT: begin
        issue      = 1'b1;
        issue_last = (ei_r == job_r.ox) && (ej_r == job_r.oy);
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= cheb2_pkg::B_IDLE;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      s1_valid_r <= issue;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  // Recurrence datapath and emit counters
  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r  <= q_data;
      axis_r <= 1'b0;
      ei_r   <= '0;
      ej_r   <= '0;
    end
    if (axis_done) axis_r <= ~axis_r;
    case (state_r)
      cheb2_pkg::B_INIT: begin
        if (axis_r) begin
          ys_r[0] <= cheb2_pkg::ONE_Q27;
          if (cur_ord != '0) ys_r[IDX_W'(1)] <= cur_v;
        end else begin
          xs_r[0] <= cheb2_pkg::ONE_Q27;
          if (cur_ord != '0) xs_r[IDX_W'(1)] <= cur_v;
        end
        t1_r <= cur_v;
        t2_r <= cheb2_pkg::ONE_Q27;
        n_r  <= 3'd2;
      end
      cheb2_pkg::B_MUL: begin
        rprod_r <= cur_v * t1_r;
      end
      cheb2_pkg::B_ACC: begin
        if (axis_r) begin
          ys_r[n_r[IDX_W-1:0]] <= tn;
        end else begin
          xs_r[n_r[IDX_W-1:0]] <= tn;
        end
        t2_r <= t1_r;
        t1_r <= tn;
        n_r  <= n_r + 1'b1;
      end
      cheb2_pkg::B_EMIT: begin
        if (ej_r == job_r.oy) begin
          ej_r <= '0;
          ei_r <= ei_r + 1'b1;
        end else begin
          ej_r <= ej_r + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Emit pipeline payload
  always_ff @(posedge clk) begin
    s1_xv_r   <= xs_r[ei_r[IDX_W-1:0]];
    s1_yv_r   <= ys_r[ej_r[IDX_W-1:0]];
    s1_i_r    <= ei_r;
    s1_j_r    <= ej_r;
    s1_last_r <= issue_last;
    s2_prod_r <= s1_xv_r * s1_yv_r;
    s2_i_r    <= s1_i_r;
    s2_j_r    <= s1_j_r;
    s2_last_r <= s1_last_r;
    s3_val_r  <= cheb2_pkg::sat32(cheb2_pkg::rnd_shr(s2_prod_r, 27));
    s3_i_r    <= s2_i_r;
    s3_j_r    <= s2_j_r;
    s3_last_r <= s2_last_r;
  end

  assign out_valid       = s3_valid_r;
  assign out_x_degree    = s3_i_r;
  assign out_y_degree    = s3_j_r;
  assign out_basis_value = s3_val_r;
  assign out_last        = s3_valid_r && s3_last_r;

endmodule

[hw/rtl/chebyshev_2d_basis_eval.sv]
// Top level of the 2-D Chebyshev basis evaluator: config registers, front, queue, back.
//
//  Channel  | Handshake                  | Payload
//  ---------+----------------------------+---------------------------------------------
//  request  | start / busy               | in_x_coord, in_y_coord
//  result   | out_valid                  | out_x_degree, out_y_degree, out_basis_value,
//           |                            | out_last
//  config   | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
//  The front end holds busy after each accepted request through the scale multiply, round
//  and hand-off to the two-entry queue, longer while the queue is full.
//  Per point the back end runs the recurrence for x, then for y, on one multiplier that
//  both axes share, then issues the (ox+1)*(oy+1) basis products. Results leave through
//  the store-read, multiply and round-and-saturate stages after issue. Reset is synchronous
//  and needs no clearing pass. Results cannot be stalled.
module chebyshev_2d_basis_eval #(
  parameter int MAX_ORDER = cheb2_pkg::MAX_ORDER
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [cheb2_pkg::VAL_W-1:0]  in_x_coord,
  input  logic signed [cheb2_pkg::VAL_W-1:0]  in_y_coord,
  output logic                                out_valid,
  output logic [cheb2_pkg::ORD_W-1:0]         out_x_degree,
  output logic [cheb2_pkg::ORD_W-1:0]         out_y_degree,
  output logic signed [cheb2_pkg::VAL_W-1:0]  out_basis_value,
  output logic                                out_last,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [2:0]                          cfg_index,
  input  logic [cheb2_pkg::VAL_W-1:0]         cfg_data
);

  cheb2_pkg::cfg_t cfg_r;
  cheb2_pkg::job_t push_data, pop_data;
  logic            push_valid, q_full, q_pop, q_empty;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_order <= '0;
      cfg_r.y_order <= '0;
      cfg_r.x_upper <= 32'sd65536;
      cfg_r.y_upper <= 32'sd65536;
      cfg_r.x_scale <= 31'd16777216;
      cfg_r.y_scale <= 31'd16777216;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cheb2_pkg::REG_X_ORDER: cfg_r.x_order <= cfg_data[cheb2_pkg::ORD_W-1:0];
        cheb2_pkg::REG_Y_ORDER: cfg_r.y_order <= cfg_data[cheb2_pkg::ORD_W-1:0];
        cheb2_pkg::REG_X_UPPER: cfg_r.x_upper <= $signed(cfg_data);
        cheb2_pkg::REG_Y_UPPER: cfg_r.y_upper <= $signed(cfg_data);
        cheb2_pkg::REG_X_SCALE: cfg_r.x_scale <= cfg_data[cheb2_pkg::SCALE_W-1:0];
        cheb2_pkg::REG_Y_SCALE: cfg_r.y_scale <= cfg_data[cheb2_pkg::SCALE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  cheb2_front #(
    .MAX_ORDER (MAX_ORDER)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .x_coord    (in_x_coord),
    .y_coord    (in_y_coord),
    .cfg        (cfg_r),
    .push_valid (push_valid),
    .push_data  (push_data),
    .q_full     (q_full)
  );

  cheb2_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .full       (q_full),
    .pop        (q_pop),
    .pop_data   (pop_data),
    .empty      (q_empty)
  );

  cheb2_back #(
    .MAX_ORDER (MAX_ORDER)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_data          (pop_data),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_x_degree    (out_x_degree),
    .out_y_degree    (out_y_degree),
    .out_basis_value (out_basis_value),
    .out_last        (out_last)
  );

endmodule

[hw/rtl/cheb2_checker.sv]
// Port-level checks for the 2-D Chebyshev basis evaluator, bound to the top level.
module cheb2_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                start,
  input logic                                busy,
  input logic                                out_valid,
  input logic [cheb2_pkg::ORD_W-1:0]         out_x_degree,
  input logic [cheb2_pkg::ORD_W-1:0]         out_y_degree,
  input logic signed [cheb2_pkg::VAL_W-1:0]  out_basis_value,
  input logic                                out_last
);

  // An accepted request keeps the front busy in the following cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("front not busy after request accepted");

  // Results of one point come out in consecutive cycles
  a_run_dense: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid)
    else $error("gap inside a result run");

  // Within a run the y degree steps, or wraps to zero while the x degree steps
  a_degree_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=>
      ((out_x_degree == $past(out_x_degree)) &&
       (out_y_degree == $past(out_y_degree) + 3'd1)) ||
      ((out_y_degree == 3'd0) &&
       (out_x_degree == $past(out_x_degree) + 3'd1)))
    else $error("degree pair out of sequence");

  // T0*T0 is exactly one
  a_unit_corner: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_x_degree == 3'd0) && (out_y_degree == 3'd0) |->
      out_basis_value == cheb2_pkg::ONE_Q27)
    else $error("T0*T0 is not one");

endmodule

bind chebyshev_2d_basis_eval cheb2_checker u_cheb2_checker (.*);

[verif/tb_chebyshev_2d_basis_eval.sv]
// Self-checking testbench for the 2-D Chebyshev basis evaluator.
module tb_chebyshev_2d_basis_eval;

  // Widths and constants taken from the shared package
  localparam int VAL_W     = cheb2_pkg::VAL_W;
  localparam int ORD_W     = cheb2_pkg::ORD_W;
  localparam int SCALE_W   = cheb2_pkg::SCALE_W;
  localparam int MAX_ORDER = cheb2_pkg::MAX_ORDER;
  localparam logic signed [VAL_W-1:0] ONE_Q27 = cheb2_pkg::ONE_Q27;

  localparam int CYCLE_LIMIT   = 300000;
  localparam int SETTLE_CYCLES = 12;

  // Indexes past the register list; writes there must be dropped
  localparam logic [2:0] REG_SPARE_6 = 3'd6;
  localparam logic [2:0] REG_SPARE_7 = 3'd7;

  // Common Q16.16 points
  localparam logic signed [VAL_W-1:0] Q16_ONE     = 32'sh0001_0000;
  localparam logic signed [VAL_W-1:0] Q16_NEG_ONE = 32'shFFFF_0000;
  localparam logic signed [VAL_W-1:0] Q16_HALF    = 32'sh0000_8000;
  localparam logic signed [VAL_W-1:0] Q16_NEG_HLF = 32'shFFFF_8000;
  localparam logic signed [VAL_W-1:0] COORD_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] COORD_MIN   = 32'sh8000_0000;
  // 1.0 in Q7.24
  localparam logic [31:0]             SCALE_ONE   = 32'h0100_0000;

  // One product term as the block emits it
  typedef struct packed {
    logic [ORD_W-1:0]        xd;
    logic [ORD_W-1:0]        yd;
    logic signed [VAL_W-1:0] val;
    logic                    last;
  } basis_term_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       start = 1'b0;
  logic                       busy;
  logic signed [VAL_W-1:0]    in_x_coord = '0;
  logic signed [VAL_W-1:0]    in_y_coord = '0;
  logic                       out_valid;
  logic [ORD_W-1:0]           out_x_degree;
  logic [ORD_W-1:0]           out_y_degree;
  logic signed [VAL_W-1:0]    out_basis_value;
  logic                       out_last;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [2:0]                 cfg_index = '0;
  logic [VAL_W-1:0]           cfg_data = '0;

  // Register mirror, starting from the reset values
  logic [ORD_W-1:0]           x_ord_q = '0;
  logic [ORD_W-1:0]           y_ord_q = '0;
  logic signed [VAL_W-1:0]    x_top_q = Q16_ONE;
  logic signed [VAL_W-1:0]    y_top_q = Q16_ONE;
  logic [SCALE_W-1:0]         x_scl_q = 31'h0100_0000;
  logic [SCALE_W-1:0]         y_scl_q = 31'h0100_0000;

  basis_term_t                pending_terms[$];
  basis_term_t                head_term;
  int                         mismatches = 0;
  int                         cycle_count = 0;
  bit                         burst_mode = 1'b0;

  chebyshev_2d_basis_eval i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_x_coord      (in_x_coord),
    .in_y_coord      (in_y_coord),
    .out_valid       (out_valid),
    .out_x_degree    (out_x_degree),
    .out_y_degree    (out_y_degree),
    .out_basis_value (out_basis_value),
    .out_last        (out_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #5 clk = ~clk;

  // Fixed-point helpers: round to nearest (ties up) and clamp to 32 bits
  function automatic longint shr_round(input longint v, input int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [VAL_W-1:0] clamp_q27(input longint v);
    if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return 32'sh8000_0000;
    return v[VAL_W-1:0];
  endfunction

  // scale * (v - top) + 1.0, result in Q4.27
  function automatic logic signed [VAL_W-1:0] domain_map(input logic signed [VAL_W-1:0] v,
                                                         input logic signed [VAL_W-1:0] top,
                                                         input logic [SCALE_W-1:0] scl);
    longint d;
    d = longint'(v) - longint'(top);
    return clamp_q27(shr_round(d * longint'(scl), 13) + longint'(ONE_Q27));
  endfunction

  // T(n) = 2 v T(n-1) - T(n-2)
  function automatic logic signed [VAL_W-1:0] next_term(input logic signed [VAL_W-1:0] v,
                                                        input logic signed [VAL_W-1:0] t1,
                                                        input logic signed [VAL_W-1:0] t2);
    return clamp_q27(shr_round(longint'(v) * longint'(t1), 26) - longint'(t2));
  endfunction

  // Queue every product term that one point produces, x degree outer
  function automatic void predict_point(input logic signed [VAL_W-1:0] x,
                                        input logic signed [VAL_W-1:0] y);
    logic signed [VAL_W-1:0] tx [8];
    logic signed [VAL_W-1:0] ty [8];
    basis_term_t             t;
    int                      n, i, j;
    tx[0] = ONE_Q27;
    ty[0] = ONE_Q27;
    tx[1] = domain_map(x, x_top_q, x_scl_q);
    ty[1] = domain_map(y, y_top_q, y_scl_q);
    for (n = 2; n <= MAX_ORDER; n++) begin
      tx[n] = next_term(tx[1], tx[n-1], tx[n-2]);
      ty[n] = next_term(ty[1], ty[n-1], ty[n-2]);
    end
    for (i = 0; i <= x_ord_q; i++) begin
      for (j = 0; j <= y_ord_q; j++) begin
        t.xd   = i[ORD_W-1:0];
        t.yd   = j[ORD_W-1:0];
        t.val  = clamp_q27(shr_round(longint'(tx[i]) * longint'(ty[j]), 27));
        t.last = (i == x_ord_q) && (j == y_ord_q);
        pending_terms.push_back(t);
      end
    end
  endfunction

  task automatic note_mismatch(input string field, input longint exp_v, input longint got_v);
    mismatches++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, got_v);
  endtask

  // Result checker: every strobe is matched against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_terms.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing expected, expected none, actual (%0d,%0d) %0d",
                 $time, out_x_degree, out_y_degree, out_basis_value);
      end else begin
        head_term = pending_terms.pop_front();
        if (out_x_degree !== head_term.xd)
          note_mismatch("x_degree", head_term.xd, out_x_degree);
        if (out_y_degree !== head_term.yd)
          note_mismatch("y_degree", head_term.yd, out_y_degree);
        if (out_basis_value !== head_term.val)
          note_mismatch("basis_value", head_term.val, out_basis_value);
        if (out_last !== head_term.last)
          note_mismatch("last", head_term.last, out_last);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // One register write; leaves cfg_valid high so writes can chain
  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      cheb2_pkg::REG_X_ORDER: x_ord_q = data[ORD_W-1:0];
      cheb2_pkg::REG_Y_ORDER: y_ord_q = data[ORD_W-1:0];
      cheb2_pkg::REG_X_UPPER: x_top_q = data;
      cheb2_pkg::REG_Y_UPPER: y_top_q = data;
      cheb2_pkg::REG_X_SCALE: x_scl_q = data[SCALE_W-1:0];
      cheb2_pkg::REG_Y_SCALE: y_scl_q = data[SCALE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_settings(input logic [31:0] xo, input logic [31:0] yo,
                                input logic [31:0] xt, input logic [31:0] yt,
                                input logic [31:0] xs, input logic [31:0] ys);
    cfg_write(cheb2_pkg::REG_X_ORDER, xo);
    cfg_write(cheb2_pkg::REG_Y_ORDER, yo);
    cfg_write(cheb2_pkg::REG_X_UPPER, xt);
    cfg_write(cheb2_pkg::REG_Y_UPPER, yt);
    cfg_write(cheb2_pkg::REG_X_SCALE, xs);
    cfg_write(cheb2_pkg::REG_Y_SCALE, ys);
    cfg_valid <= 1'b0;
  endtask

  // Issue one request; start stays high so a zero gap runs back to back
  task automatic send_point(input logic signed [VAL_W-1:0] x, input logic signed [VAL_W-1:0] y);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    in_x_coord <= x;
    in_y_coord <= y;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_point(x, y);
  endtask

  // Stop requesting until all results are back and the pipeline is empty
  task automatic settle_idle();
    start <= 1'b0;
    while (pending_terms.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register defaults: both orders zero, one term per point
  task automatic test_reset_state();
    send_point('0, '0);
    send_point(COORD_MAX, COORD_MIN);
  endtask

  // Full orders on [-1,1]; unused indexes and high data bits must be ignored
  task automatic test_order_extremes();
    settle_idle();
    cfg_write(REG_SPARE_6, 32'hFFFF_FFFF);
    cfg_write(REG_SPARE_7, 32'h8000_0001);
    write_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, Q16_ONE, Q16_ONE, SCALE_ONE, SCALE_ONE);
    burst_mode = 1'b1;
    send_point(Q16_ONE, Q16_ONE);
    send_point(Q16_NEG_ONE, Q16_NEG_ONE);
    send_point('0, '0);
    send_point(Q16_HALF, Q16_NEG_HLF);
    send_point(32'sh0000_C000, 32'sh0000_4000);
    burst_mode = 1'b0;
  endtask

  // Lopsided orders: x only, y only, and a mid mix
  task automatic test_mixed_orders();
    int xo_list [3];
    int yo_list [3];
    int k;
    xo_list = '{7, 0, 3};
    yo_list = '{0, 7, 5};
    for (k = 0; k < 3; k++) begin
      settle_idle();
      write_settings(xo_list[k], yo_list[k], Q16_ONE, Q16_ONE, SCALE_ONE, SCALE_ONE);
      send_point(Q16_HALF, Q16_NEG_HLF);
    end
  endtask

  // Mapping, recurrence and product saturation; zero scale pins v' at 1.0
  task automatic test_saturation();
    settle_idle();
    write_settings(7, 7, COORD_MIN, COORD_MIN, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_point(COORD_MAX, COORD_MAX);
    send_point(COORD_MIN, COORD_MIN);
    send_point('0, COORD_MAX);
    settle_idle();
    write_settings(7, 7, COORD_MAX, COORD_MAX, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(COORD_MIN, COORD_MIN);
    send_point(COORD_MIN, COORD_MAX);
    settle_idle();
    write_settings(7, 7, '0, '0, '0, '0);
    send_point(32'sh1234_5678, COORD_MIN);
  endtask

  function automatic logic signed [VAL_W-1:0] draw_coord(input logic signed [VAL_W-1:0] top,
                                                         input int span, input bit wild);
    if (wild || $urandom_range(0, 6) == 0) return $urandom;
    return top - $urandom_range(0, span);
  endfunction

  // Random settings, then random points mostly inside the mapped domain
  task automatic test_random_points(input int n_items, input bit no_gaps);
    int                      xo, yo, xspan, yspan, k;
    bit                      wild;
    logic signed [VAL_W-1:0] xt, yt;
    logic [31:0]             xs, ys;
    settle_idle();
    wild  = ($urandom_range(0, 4) == 0);
    xo    = $urandom_range(0, MAX_ORDER);
    yo    = $urandom_range(0, MAX_ORDER);
    xspan = $urandom_range(1 << 14, 8 << 16);
    yspan = $urandom_range(1 << 14, 8 << 16);
    if (wild) begin
      xt = $urandom;
      yt = $urandom;
      xs = $urandom;
      ys = $urandom;
    end else begin
      // domain width in Q16.16 -> 2/width in Q7.24
      xt = $urandom_range(0, 8 << 16) - (4 << 16);
      yt = $urandom_range(0, 8 << 16) - (4 << 16);
      xs = 32'((64'd1 << 41) / xspan);
      ys = 32'((64'd1 << 41) / yspan);
    end
    write_settings(xo, yo, xt, yt, xs, ys);
    burst_mode = no_gaps;
    for (k = 0; k < n_items; k++) begin
      if ($urandom_range(0, 39) == 0) settle_idle();
      send_point(draw_coord(xt, xspan, wild), draw_coord(yt, yspan, wild));
    end
    burst_mode = 1'b0;
  endtask

  initial begin
    int phase;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_order_extremes();
    test_mixed_orders();
    test_saturation();
    for (phase = 0; phase < 6; phase++)
      test_random_points(30, phase % 3 == 1);
    settle_idle();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
